// ===== rtl/vp8fh_pkg.sv =====
// Shared types, constants and the header-parse microcode ROM for the VP8 frame header parser.
`default_nettype none

package vp8fh_pkg;

	// Frame layout constants
	localparam logic [19:0] BYTES_MAX     = 20'hFFFFF;
	localparam logic [19:0] TAG_BYTES     = 20'd3;
	localparam logic [19:0] KEY_MIN_BYTES = 20'd10;
	localparam logic [7:0]  START_CODE0   = 8'h9D;
	localparam logic [7:0]  START_CODE1   = 8'h01;
	localparam logic [7:0]  START_CODE2   = 8'h2A;
	localparam logic [7:0]  RANGE_INIT    = 8'd255;

	// Micro program counter: one step per header field position
	typedef logic [4:0] step_t;

	localparam step_t ST_PRIME_HI   = 5'd0;
	localparam step_t ST_PRIME_LO   = 5'd1;
	localparam step_t ST_SEG_EN     = 5'd2;
	localparam step_t ST_UPD_MAP    = 5'd3;
	localparam step_t ST_UPD_DATA   = 5'd4;
	localparam step_t ST_SEG_MODE   = 5'd5;
	localparam step_t ST_SEGQ_FLAG  = 5'd6;
	localparam step_t ST_SEGQ_VAL   = 5'd7;
	localparam step_t ST_SEGQ_SIGN  = 5'd8;
	localparam step_t ST_SEGLF_FLAG = 5'd9;
	localparam step_t ST_SEGLF_VAL  = 5'd10;
	localparam step_t ST_SEGLF_SIGN = 5'd11;
	localparam step_t ST_PROB_FLAG  = 5'd12;
	localparam step_t ST_PROB_VAL   = 5'd13;
	localparam step_t ST_LF_TYPE    = 5'd14;
	localparam step_t ST_LF_LEVEL   = 5'd15;
	localparam step_t ST_LF_SHARP   = 5'd16;
	localparam step_t ST_LF_ADJ     = 5'd17;
	localparam step_t ST_DELTA_UPD  = 5'd18;
	localparam step_t ST_DELTA_FLAG = 5'd19;
	localparam step_t ST_DELTA_VAL  = 5'd20;
	localparam step_t ST_DELTA_SIGN = 5'd21;
	localparam step_t ST_PART_COUNT = 5'd22;
	localparam step_t ST_YAC        = 5'd23;
	localparam step_t ST_QD_FLAG    = 5'd24;
	localparam step_t ST_QD_VAL     = 5'd25;
	localparam step_t ST_QD_SIGN    = 5'd26;
	localparam step_t ST_REF_GOLD   = 5'd27;
	localparam step_t ST_REF_ALT    = 5'd28;
	localparam step_t ST_COPY_GOLD  = 5'd29;
	localparam step_t ST_COPY_ALT   = 5'd30;
	localparam step_t ST_DONE       = 5'd31;

	// Bit positions in the decoded flag register
	localparam logic [2:0] FL_SEG_MAP = 3'd0;
	localparam logic [2:0] FL_GOLD    = 3'd2;
	localparam logic [2:0] FL_ALT     = 3'd3;
	localparam logic [2:0] FL_CGOLD   = 3'd4;
	localparam logic [2:0] FL_CALT    = 3'd6;
	localparam logic [2:0] FL_NONE    = 3'd0;

	localparam logic [3:0] LIT_NONE = 4'd0;

	// What a step does with its decoded bit
	typedef enum logic [2:0] {
		K_PRIME_HI = 3'd0,
		K_PRIME_LO = 3'd1,
		K_GO       = 3'd2,
		K_BRANCH   = 3'd3,
		K_LIT      = 3'd4,
		K_FLAG     = 3'd5,
		K_COPY     = 3'd6,
		K_HALT     = 3'd7
	} kind_t;

	// How a jump target is resolved
	typedef enum logic [2:0] {
		M_GO        = 3'd0,
		M_AFTER_SEG = 3'd1,
		M_AFTER_REF = 3'd2,
		M_AFTER_CG  = 3'd3,
		M_LOOP      = 3'd4
	} dmode_t;

	typedef struct packed {
		dmode_t     mode;
		step_t      step;
		logic [3:0] nbits;
	} dest_t;

	typedef struct packed {
		step_t      step;
		logic [3:0] nbits;
	} jump_t;

	typedef struct packed {
		kind_t      kind;
		logic [2:0] fidx;
		dest_t      da;
		dest_t      db;
		dest_t      dx;
		step_t      loop_step;
		logic [3:0] loop_cnt;
	} uword_t;

	// Top level to bool decoder
	typedef struct packed {
		logic       load;
		logic [7:0] data;
		logic       exhaust;
		logic       clear;
	} seq_ctl_t;

	// Bool decoder to top level
	typedef struct packed {
		logic       active;
		logic       overrun;
		logic       golden_refresh;
		logic       altref_refresh;
		logic [1:0] golden_copy;
		logic [1:0] altref_copy;
	} seq_stat_t;

	function automatic dest_t dgo(step_t s, logic [3:0] n);
		dest_t d;
		d.mode  = M_GO;
		d.step  = s;
		d.nbits = n;
		return d;
	endfunction

	function automatic dest_t dsp(dmode_t m);
		dest_t d;
		d.mode  = m;
		d.step  = ST_PRIME_HI;
		d.nbits = LIT_NONE;
		return d;
	endfunction

	function automatic uword_t mkw(kind_t k, logic [2:0] f, dest_t a, dest_t b, dest_t x,
			step_t ls, logic [3:0] lc);
		uword_t w;
		w.kind      = k;
		w.fidx      = f;
		w.da        = a;
		w.db        = b;
		w.dx        = x;
		w.loop_step = ls;
		w.loop_cnt  = lc;
		return w;
	endfunction

	// Header-parse program, one control word per step
	function automatic uword_t ucode(step_t s);
		uword_t w;
		dest_t  dn;
		dn = dgo(ST_PRIME_HI, LIT_NONE);
		case (s)
			ST_PRIME_HI:   w = mkw(K_PRIME_HI, FL_NONE, dgo(ST_PRIME_LO, LIT_NONE), dn, dn,
				ST_PRIME_HI, 4'd0);
			ST_PRIME_LO:   w = mkw(K_PRIME_LO, FL_NONE, dgo(ST_SEG_EN, LIT_NONE), dn, dn,
				ST_PRIME_HI, 4'd0);
			ST_SEG_EN:     w = mkw(K_BRANCH, FL_NONE, dgo(ST_UPD_MAP, LIT_NONE),
				dgo(ST_LF_TYPE, LIT_NONE), dn, ST_PRIME_HI, 4'd0);
			ST_UPD_MAP:    w = mkw(K_FLAG, FL_SEG_MAP, dgo(ST_UPD_DATA, LIT_NONE), dn, dn,
				ST_PRIME_HI, 4'd0);
			ST_UPD_DATA:   w = mkw(K_BRANCH, FL_NONE, dgo(ST_SEG_MODE, LIT_NONE),
				dsp(M_AFTER_SEG), dn, ST_PRIME_HI, 4'd0);
			ST_SEG_MODE:   w = mkw(K_GO, FL_NONE, dgo(ST_SEGQ_FLAG, LIT_NONE), dn, dn,
				ST_PRIME_HI, 4'd0);
			ST_SEGQ_FLAG:  w = mkw(K_BRANCH, FL_NONE, dgo(ST_SEGQ_VAL, 4'd7), dsp(M_LOOP),
				dgo(ST_SEGLF_FLAG, LIT_NONE), ST_SEGQ_FLAG, 4'd4);
			ST_SEGQ_VAL:   w = mkw(K_LIT, FL_NONE, dgo(ST_SEGQ_SIGN, LIT_NONE), dn, dn,
				ST_PRIME_HI, 4'd0);
			ST_SEGQ_SIGN:  w = mkw(K_GO, FL_NONE, dsp(M_LOOP), dn,
				dgo(ST_SEGLF_FLAG, LIT_NONE), ST_SEGQ_FLAG, 4'd4);
			ST_SEGLF_FLAG: w = mkw(K_BRANCH, FL_NONE, dgo(ST_SEGLF_VAL, 4'd6), dsp(M_LOOP),
				dsp(M_AFTER_SEG), ST_SEGLF_FLAG, 4'd4);
			ST_SEGLF_VAL:  w = mkw(K_LIT, FL_NONE, dgo(ST_SEGLF_SIGN, LIT_NONE), dn, dn,
				ST_PRIME_HI, 4'd0);
			ST_SEGLF_SIGN: w = mkw(K_GO, FL_NONE, dsp(M_LOOP), dn, dsp(M_AFTER_SEG),
				ST_SEGLF_FLAG, 4'd4);
			ST_PROB_FLAG:  w = mkw(K_BRANCH, FL_NONE, dgo(ST_PROB_VAL, 4'd8), dsp(M_LOOP),
				dgo(ST_LF_TYPE, LIT_NONE), ST_PROB_FLAG, 4'd3);
			ST_PROB_VAL:   w = mkw(K_LIT, FL_NONE, dsp(M_LOOP), dn,
				dgo(ST_LF_TYPE, LIT_NONE), ST_PROB_FLAG, 4'd3);
			ST_LF_TYPE:    w = mkw(K_GO, FL_NONE, dgo(ST_LF_LEVEL, 4'd6), dn, dn,
				ST_PRIME_HI, 4'd0);
			ST_LF_LEVEL:   w = mkw(K_LIT, FL_NONE, dgo(ST_LF_SHARP, 4'd3), dn, dn,
				ST_PRIME_HI, 4'd0);
			ST_LF_SHARP:   w = mkw(K_LIT, FL_NONE, dgo(ST_LF_ADJ, LIT_NONE), dn, dn,
				ST_PRIME_HI, 4'd0);
			ST_LF_ADJ:     w = mkw(K_BRANCH, FL_NONE, dgo(ST_DELTA_UPD, LIT_NONE),
				dgo(ST_PART_COUNT, 4'd2), dn, ST_PRIME_HI, 4'd0);
			ST_DELTA_UPD:  w = mkw(K_BRANCH, FL_NONE, dgo(ST_DELTA_FLAG, LIT_NONE),
				dgo(ST_PART_COUNT, 4'd2), dn, ST_PRIME_HI, 4'd0);
			ST_DELTA_FLAG: w = mkw(K_BRANCH, FL_NONE, dgo(ST_DELTA_VAL, 4'd6), dsp(M_LOOP),
				dgo(ST_PART_COUNT, 4'd2), ST_DELTA_FLAG, 4'd8);
			ST_DELTA_VAL:  w = mkw(K_LIT, FL_NONE, dgo(ST_DELTA_SIGN, LIT_NONE), dn, dn,
				ST_PRIME_HI, 4'd0);
			ST_DELTA_SIGN: w = mkw(K_GO, FL_NONE, dsp(M_LOOP), dn, dgo(ST_PART_COUNT, 4'd2),
				ST_DELTA_FLAG, 4'd8);
			ST_PART_COUNT: w = mkw(K_LIT, FL_NONE, dgo(ST_YAC, 4'd7), dn, dn,
				ST_PRIME_HI, 4'd0);
			ST_YAC:        w = mkw(K_LIT, FL_NONE, dgo(ST_QD_FLAG, LIT_NONE), dn, dn,
				ST_PRIME_HI, 4'd0);
			ST_QD_FLAG:    w = mkw(K_BRANCH, FL_NONE, dgo(ST_QD_VAL, 4'd4), dsp(M_LOOP),
				dgo(ST_REF_GOLD, LIT_NONE), ST_QD_FLAG, 4'd5);
			ST_QD_VAL:     w = mkw(K_LIT, FL_NONE, dgo(ST_QD_SIGN, LIT_NONE), dn, dn,
				ST_PRIME_HI, 4'd0);
			ST_QD_SIGN:    w = mkw(K_GO, FL_NONE, dsp(M_LOOP), dn, dgo(ST_REF_GOLD, LIT_NONE),
				ST_QD_FLAG, 4'd5);
			ST_REF_GOLD:   w = mkw(K_FLAG, FL_GOLD, dgo(ST_REF_ALT, LIT_NONE), dn, dn,
				ST_PRIME_HI, 4'd0);
			ST_REF_ALT:    w = mkw(K_FLAG, FL_ALT, dsp(M_AFTER_REF), dn, dn,
				ST_PRIME_HI, 4'd0);
			ST_COPY_GOLD:  w = mkw(K_COPY, FL_CGOLD, dsp(M_AFTER_CG), dn, dn,
				ST_PRIME_HI, 4'd0);
			ST_COPY_ALT:   w = mkw(K_COPY, FL_CALT, dgo(ST_DONE, LIT_NONE), dn, dn,
				ST_PRIME_HI, 4'd0);
			default:       w = mkw(K_HALT, FL_NONE, dgo(ST_DONE, LIT_NONE), dn, dn,
				ST_PRIME_HI, 4'd0);
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/vp8fh_in_if.sv =====
// Byte input channel of the VP8 frame header parser.
`default_nettype none

interface vp8fh_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       end_of_frame;

	modport source (output valid, output frame_byte, output end_of_frame, input ready);
	modport sink (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

`default_nettype wire

// ===== rtl/vp8fh_out_if.sv =====
// Result channel of the VP8 frame header parser.
`default_nettype none

interface vp8fh_out_if;
	logic       valid;
	logic       ready;
	logic       header_ok;
	logic       is_key_frame;
	logic       is_shown;
	logic       golden_refresh;
	logic       altref_refresh;
	logic [1:0] golden_copy_code;
	logic [1:0] altref_copy_code;

	modport source (output valid, output header_ok, output is_key_frame, output is_shown,
		output golden_refresh, output altref_refresh, output golden_copy_code,
		output altref_copy_code, input ready);
	modport sink (input valid, input header_ok, input is_key_frame, input is_shown,
		input golden_refresh, input altref_refresh, input golden_copy_code,
		input altref_copy_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/vp8fh_bool_seq.sv =====
// Microcoded boolean decoder (probability 128) that walks the inter-frame header fields.
`default_nettype none

module vp8fh_bool_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vp8fh_pkg::seq_ctl_t  ctl,
	output vp8fh_pkg::seq_stat_t stat
);
	import vp8fh_pkg::*;

	step_t      step_q;
	logic [2:0] rep_q;
	logic [7:0] acc_q;
	logic [3:0] left_q;
	logic [7:0] range_q;
	logic [16:0] value_q;
	logic [2:0] shift_q;
	logic [7:0] flags_q;
	logic       overrun_q;
	logic [7:0] held_q;
	logic       held_valid_q;
	logic       exh_q;

	logic        active;
	uword_t      uw;
	logic [7:0]  take_byte;
	logic        is_prime;
	logic        take_now;
	logic [7:0]  split;
	logic [16:0] scaled;
	logic        dbit;
	logic [7:0]  range_a;
	logic [16:0] value_a;
	logic        renorm;
	logic [2:0]  shift_nx;
	logic        need_byte;
	logic [7:0]  range_b;
	logic [16:0] value_b;
	logic [7:0]  lit_acc;
	logic [3:0]  lit_left;
	logic        lit_done;
	logic        jump;
	dest_t       dsel;
	jump_t       jsel;
	step_t       step_nx;
	logic [2:0]  rep_nx;
	logic [7:0]  acc_nx;
	logic [3:0]  left_nx;
	logic [7:0]  flags_nx;

	// Targets that depend on flags decoded earlier
	function automatic jump_t resolve(dest_t d, logic [7:0] f);
		jump_t j;
		j.step  = d.step;
		j.nbits = d.nbits;
		case (d.mode)
			M_GO: begin
				j.step  = d.step;
				j.nbits = d.nbits;
			end
			M_AFTER_SEG: begin
				j.step  = f[FL_SEG_MAP] ? ST_PROB_FLAG : ST_LF_TYPE;
				j.nbits = LIT_NONE;
			end
			M_AFTER_REF: begin
				if (!f[FL_GOLD]) begin
					j.step  = ST_COPY_GOLD;
					j.nbits = 4'd2;
				end else if (!f[FL_ALT]) begin
					j.step  = ST_COPY_ALT;
					j.nbits = 4'd2;
				end else begin
					j.step  = ST_DONE;
					j.nbits = LIT_NONE;
				end
			end
			M_AFTER_CG: begin
				j.step  = f[FL_ALT] ? ST_DONE : ST_COPY_ALT;
				j.nbits = f[FL_ALT] ? LIT_NONE : 4'd2;
			end
			default: begin
				j.step  = d.step;
				j.nbits = d.nbits;
			end
		endcase
		return j;
	endfunction

	// Control word fetch and bit decode datapath
	always_comb begin
		active    = (step_q != ST_DONE) && (held_valid_q || exh_q);
		uw        = ucode(step_q);
		take_byte = held_valid_q ? held_q : 8'h00;
		is_prime  = (uw.kind == K_PRIME_HI) || (uw.kind == K_PRIME_LO);

		split   = 8'((range_q - 8'd1) >> 1) + 8'd1;
		scaled  = {1'b0, split, 8'h00};
		dbit    = (value_q >= scaled);
		range_a = dbit ? (range_q - split) : split;
		value_a = dbit ? (value_q - scaled) : value_q;

		// At probability 128 the range never drops below 64: one shift at most
		renorm    = !range_a[7];
		shift_nx  = renorm ? (shift_q + 3'd1) : shift_q;
		need_byte = renorm && (shift_nx == 3'd0);
		range_b   = renorm ? {range_a[6:0], 1'b0} : range_a;
		value_b   = renorm ? ({value_a[15:0], 1'b0} | (need_byte ? {9'd0, take_byte} : 17'd0))
			: value_a;

		take_now = active && (is_prime || need_byte);

		lit_acc  = {acc_q[6:0], dbit};
		lit_left = (left_q != 4'd0) ? (left_q - 4'd1) : 4'd0;
		lit_done = (lit_left == 4'd0);
	end

	// Next-step selection from the control word
	always_comb begin
		flags_nx = flags_q;
		jump     = 1'b0;
		dsel     = uw.da;
		case (uw.kind)
			K_GO: begin
				jump = 1'b1;
			end
			K_FLAG: begin
				jump = 1'b1;
				flags_nx[uw.fidx] = flags_q[uw.fidx] | dbit;
			end
			K_BRANCH: begin
				jump = 1'b1;
				dsel = dbit ? uw.da : uw.db;
			end
			K_LIT: begin
				jump = lit_done;
			end
			K_COPY: begin
				jump = lit_done;
				if (lit_done) begin
					if (uw.fidx == FL_CGOLD)
						flags_nx[5:4] = flags_q[5:4] | lit_acc[1:0];
					else
						flags_nx[7:6] = flags_q[7:6] | lit_acc[1:0];
				end
			end
			default: begin
				jump = 1'b0;
			end
		endcase

		step_nx = step_q;
		rep_nx  = rep_q;
		acc_nx  = lit_acc;
		left_nx = lit_left;
		jsel    = resolve(dsel, flags_nx);
		if (jump) begin
			if (dsel.mode == M_LOOP) begin
				if (({1'b0, rep_q} + 4'd1) < uw.loop_cnt) begin
					rep_nx     = rep_q + 3'd1;
					jsel.step  = uw.loop_step;
					jsel.nbits = LIT_NONE;
				end else begin
					rep_nx = 3'd0;
					jsel   = resolve(uw.dx, flags_nx);
				end
			end
			step_nx = jsel.step;
			acc_nx  = 8'h00;
			left_nx = jsel.nbits;
		end
	end

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= ST_PRIME_HI;
			rep_q        <= 3'd0;
			acc_q        <= 8'h00;
			left_q       <= 4'd0;
			range_q      <= RANGE_INIT;
			value_q      <= 17'd0;
			shift_q      <= 3'd0;
			flags_q      <= 8'h00;
			overrun_q    <= 1'b0;
			held_valid_q <= 1'b0;
			exh_q        <= 1'b0;
		end else if (ctl.clear) begin
			step_q       <= ST_PRIME_HI;
			rep_q        <= 3'd0;
			acc_q        <= 8'h00;
			left_q       <= 4'd0;
			range_q      <= RANGE_INIT;
			value_q      <= 17'd0;
			shift_q      <= 3'd0;
			flags_q      <= 8'h00;
			overrun_q    <= 1'b0;
			held_valid_q <= 1'b0;
			exh_q        <= 1'b0;
		end else begin
			if (ctl.load) begin
				held_valid_q <= 1'b1;
				if (ctl.exhaust)
					exh_q <= 1'b1;
			end
			if (active) begin
				// past the partition end the decoder reads zeros
				if (take_now) begin
					held_valid_q <= 1'b0;
					if (!held_valid_q)
						overrun_q <= 1'b1;
				end
				case (uw.kind)
					K_PRIME_HI: begin
						value_q <= {1'b0, take_byte, 8'h00};
						step_q  <= uw.da.step;
					end
					K_PRIME_LO: begin
						value_q <= value_q | {9'd0, take_byte};
						step_q  <= uw.da.step;
					end
					default: begin
						range_q <= range_b;
						value_q <= value_b;
						shift_q <= shift_nx;
						step_q  <= step_nx;
						rep_q   <= rep_nx;
						acc_q   <= acc_nx;
						left_q  <= left_nx;
						flags_q <= flags_nx;
					end
				endcase
			end
		end
	end

	// Held byte payload
	always_ff @(posedge clk) begin
		if (ctl.load)
			held_q <= ctl.data;
	end

	assign stat.active         = active;
	assign stat.overrun        = overrun_q;
	assign stat.golden_refresh = flags_q[FL_GOLD];
	assign stat.altref_refresh = flags_q[FL_ALT];
	assign stat.golden_copy    = flags_q[5:4];
	assign stat.altref_copy    = flags_q[7:6];

	// Range stays normalized after every decoded bit
	a_range_norm: assert property (@(posedge clk) disable iff (!arst_n) range_q[7])
		else $error("bool decoder range lost normalization");

	// A new byte only lands while the decoder waits for one
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> !active)
		else $error("byte loaded while decoder busy");

	// Frame clear returns the decoder to priming
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |=> (step_q == ST_PRIME_HI) && !held_valid_q && !exh_q)
		else $error("decoder not reset by frame clear");

	// Coder state only moves while decoding
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!active && !ctl.clear) |=> ($stable(value_q) && $stable(range_q)))
		else $error("coder state changed while idle");

endmodule

`default_nettype wire

// ===== rtl/vp8_frame_header_parser_core.sv =====
// VP8 frame header parser: top level with byte bookkeeping and result register.
//
// Usage: frame bytes enter on frame_in, one beat per byte, with end_of_frame set on
// the final byte. One result beat per frame leaves on result_out.
// A byte outside the first partition of an inter frame is simply accepted. A byte of the
// first partition of an inter frame is accepted and then decoded by the microcoded
// bool decoder, about eight header bits per byte, with the first two bytes used for
// priming; frame_in.ready is low meanwhile. When the partition ends, the decoder runs
// to the last header field at one bit per cycle, reading zeros if the partition was
// too short.
// After the final byte is accepted the result is registered once the decoder finishes
// and the result register is free; frame_in.ready stays low from the final beat until
// the result is registered.
// The result register parts the two sides: while it waits for result_out.ready, bytes
// of the next frame keep flowing; that frame's final beat then holds the input off
// until the slot frees.
// Reset empties the result register and returns the parser to the start of a frame;
// the same happens to the parse state after every result.
`default_nettype none

module vp8_frame_header_parser_core (
	input  logic       clk,
	input  logic       arst_n,
	vp8fh_in_if.sink   frame_in,
	vp8fh_out_if.source result_out
);
	import vp8fh_pkg::*;

	logic [19:0] bytes_seen_q;
	logic [23:0] tag_q;
	logic        start_good_q;
	logic [18:0] pending_q;
	logic        fin_q;
	logic        out_valid_q;

	logic       ok_q;
	logic       key_q;
	logic       shown_q;
	logic       gref_q;
	logic       aref_q;
	logic [1:0] gcopy_q;
	logic [1:0] acopy_q;

	seq_ctl_t  ctl;
	seq_stat_t stat;

	logic        in_fire;
	logic [7:0]  in_byte;
	logic [18:0] part;
	logic        dec_take;
	logic        res_load;
	logic        frame3;
	logic        key;
	logic        key_ok;
	logic        part_ok;
	logic        res_ok;
	logic        res_gref;
	logic        res_aref;
	logic [1:0]  res_gcopy;
	logic [1:0]  res_acopy;

	vp8fh_bool_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.stat   (stat)
	);

	// Handshake and decoder feed
	always_comb begin
		frame_in.ready = !stat.active && !fin_q;
		in_fire  = frame_in.valid && frame_in.ready;
		in_byte  = frame_in.frame_byte;
		part     = tag_q[23:5];
		dec_take = in_fire && (bytes_seen_q >= TAG_BYTES) && tag_q[0] && (part != 19'd0)
			&& (pending_q != 19'd0);
		res_load = fin_q && !stat.active && (!out_valid_q || result_out.ready);

		ctl.load    = dec_take;
		ctl.data    = in_byte;
		ctl.exhaust = (pending_q == 19'd1);
		ctl.clear   = res_load;
	end

	// Result fields from the finished frame
	always_comb begin
		frame3    = (bytes_seen_q >= TAG_BYTES);
		key       = !tag_q[0];
		key_ok    = (bytes_seen_q >= KEY_MIN_BYTES) && start_good_q;
		part_ok   = (part != 19'd0) && (pending_q == 19'd0);
		res_ok    = frame3 && (key ? key_ok : (part_ok && !stat.overrun));
		res_gref  = frame3 && (key ? key_ok : (part_ok && stat.golden_refresh));
		res_aref  = frame3 && (key ? key_ok : (part_ok && stat.altref_refresh));
		res_gcopy = (frame3 && !key && part_ok) ? stat.golden_copy : 2'd0;
		res_acopy = (frame3 && !key && part_ok) ? stat.altref_copy : 2'd0;
	end

	// Frame bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q <= 20'd0;
			tag_q        <= 24'd0;
			start_good_q <= 1'b1;
			pending_q    <= 19'd0;
			fin_q        <= 1'b0;
		end else if (res_load) begin
			bytes_seen_q <= 20'd0;
			tag_q        <= 24'd0;
			start_good_q <= 1'b1;
			pending_q    <= 19'd0;
			fin_q        <= 1'b0;
		end else if (in_fire) begin
			if (bytes_seen_q != BYTES_MAX)
				bytes_seen_q <= bytes_seen_q + 20'd1;
			if (bytes_seen_q < TAG_BYTES) begin
				case (bytes_seen_q[1:0])
					2'd0: tag_q[7:0] <= in_byte;
					2'd1: tag_q[15:8] <= in_byte;
					default: begin
						tag_q[23:16] <= in_byte;
						pending_q    <= {in_byte, tag_q[15:5]};
					end
				endcase
			end else begin
				// key frame start code
				if (((bytes_seen_q == 20'd3) && (in_byte != START_CODE0)) ||
						((bytes_seen_q == 20'd4) && (in_byte != START_CODE1)) ||
						((bytes_seen_q == 20'd5) && (in_byte != START_CODE2)))
					start_good_q <= 1'b0;
				if (dec_take)
					pending_q <= pending_q - 19'd1;
			end
			if (frame_in.end_of_frame)
				fin_q <= 1'b1;
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_load)
			out_valid_q <= 1'b1;
		else if (result_out.ready)
			out_valid_q <= 1'b0;
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (res_load) begin
			ok_q    <= res_ok;
			key_q   <= frame3 && key;
			shown_q <= frame3 && tag_q[4];
			gref_q  <= res_gref;
			aref_q  <= res_aref;
			gcopy_q <= res_gcopy;
			acopy_q <= res_acopy;
		end
	end

	assign result_out.valid            = out_valid_q;
	assign result_out.header_ok        = ok_q;
	assign result_out.is_key_frame     = key_q;
	assign result_out.is_shown         = shown_q;
	assign result_out.golden_refresh   = gref_q;
	assign result_out.altref_refresh   = aref_q;
	assign result_out.golden_copy_code = gcopy_q;
	assign result_out.altref_copy_code = acopy_q;

	// The final beat always leaves a frame finish pending
	a_eof_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && frame_in.end_of_frame) |=> fin_q)
		else $error("final beat did not mark frame finish");

	// No byte of the next frame slips in before the result is registered
	a_fin_block: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> !in_fire)
		else $error("beat accepted while a frame finish is pending");

	// A stalled result beat keeps its fields until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && !result_out.ready) |=>
		(result_out.valid &&
		$stable({ok_q, key_q, shown_q, gref_q, aref_q, gcopy_q, acopy_q})))
		else $error("result beat changed while stalled");

endmodule

`default_nettype wire
